// File: rtl/core/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the timed setpoint sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);

  localparam int unsigned ActionW    = 2;
  localparam int unsigned TimeW      = 64;
  localparam int unsigned OffsetW    = 32;
  localparam int unsigned AngleW     = 16;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned EntryNumW  = 9;
  localparam int unsigned WordW      = OffsetW + 2 * AngleW;

  typedef enum logic [ActionW-1:0] {
    ActAdd   = 2'd0,
    ActBegin = 2'd1,
    ActEnd   = 2'd2,
    ActTick  = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StsNone     = 3'd0,
    StsFired    = 3'd1,
    StsFinished = 3'd2,
    StsStored   = 3'd3,
    StsFull     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StEval = 3'b010,
    StOut  = 3'b100
  } state_e;

  typedef struct packed {
    status_e               status;
    logic [AngleW-1:0]     first_angle;
    logic [AngleW-1:0]     second_angle;
    logic [EntryNumW-1:0]  entry_number;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take the input transaction
    logic eval;   // compare the fetched entry against elapsed time
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;  // current input is a tick that has to fetch an entry
  } sts_t;

endpackage

// File: rtl/core/tss_if.sv
// ----------------------------------------------------------------------------
// tss_in_if / tss_out_if
// Valid/ready channels carrying sequencer commands and results.
// ----------------------------------------------------------------------------
interface tss_in_if;
  logic                          valid;
  logic                          ready;
  logic [tss_pkg::ActionW-1:0]   action;
  logic [tss_pkg::TimeW-1:0]     now_time;
  logic [tss_pkg::OffsetW-1:0]   entry_offset;
  logic [tss_pkg::AngleW-1:0]    first_angle;
  logic [tss_pkg::AngleW-1:0]    second_angle;

  modport source (output valid, action, now_time, entry_offset, first_angle,
                  second_angle, input ready);
  modport sink   (input valid, action, now_time, entry_offset, first_angle,
                  second_angle, output ready);
endinterface

interface tss_out_if;
  logic                          valid;
  logic                          ready;
  logic [tss_pkg::StatusW-1:0]   status;
  logic [tss_pkg::AngleW-1:0]    out_first_angle;
  logic [tss_pkg::AngleW-1:0]    out_second_angle;
  logic [tss_pkg::EntryNumW-1:0] entry_number;

  modport source (output valid, status, out_first_angle, out_second_angle,
                  entry_number, input ready);
  modport sink   (input valid, status, out_first_angle, out_second_angle,
                  entry_number, output ready);
endinterface

// File: rtl/core/tss_ctrl.sv
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencing state machine: accept, optional compare step, result hold.
// ----------------------------------------------------------------------------
module tss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tss_pkg::sts_t    sts_i,
  output tss_pkg::cmd_t    cmd_o
);

  tss_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      tss_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.need_read ? tss_pkg::StEval : tss_pkg::StOut;
        end
      end
      tss_pkg::StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = tss_pkg::StOut;
      end
      tss_pkg::StOut: begin
        if (out_ready_i) begin
          state_d = tss_pkg::StIdle;
        end
      end
      default: begin
        state_d = tss_pkg::StIdle;
      end
    endcase
  end

  assign in_ready_o  = (state_q == tss_pkg::StIdle);
  assign out_valid_o = (state_q == tss_pkg::StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tss_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/tss_dp.sv
// ----------------------------------------------------------------------------
// tss_dp
// Setpoint table, playback registers and result register.
// ----------------------------------------------------------------------------
module tss_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tss_pkg::cmd_t                 cmd_i,
  output tss_pkg::sts_t                 sts_o,
  input  logic [tss_pkg::ActionW-1:0]   action_i,
  input  logic [tss_pkg::TimeW-1:0]     now_time_i,
  input  logic [tss_pkg::OffsetW-1:0]   entry_offset_i,
  input  logic [tss_pkg::AngleW-1:0]    first_angle_i,
  input  logic [tss_pkg::AngleW-1:0]    second_angle_i,
  output tss_pkg::out_item_t            res_o
);

  logic [tss_pkg::WordW-1:0]  table_mem [tss_pkg::TableDepth];
  logic [tss_pkg::WordW-1:0]  rdata_q;

  logic [tss_pkg::CountW-1:0] count_q, count_d;
  logic [tss_pkg::CountW-1:0] pos_q, pos_d;
  logic                       playing_q, playing_d;
  logic [tss_pkg::TimeW-1:0]  start_q, start_d;
  logic [tss_pkg::TimeW-1:0]  now_q;
  tss_pkg::out_item_t         res_q, res_d;

  logic                       mem_we;
  logic                       mem_re;
  logic [tss_pkg::WordW-1:0]  wdata;
  logic [tss_pkg::TimeW-1:0]  elapsed;

  assign sts_o.need_read = (tss_pkg::action_e'(action_i) == tss_pkg::ActTick)
                           && playing_q && (pos_q < count_q);

  assign wdata   = {entry_offset_i, first_angle_i, second_angle_i};
  assign elapsed = now_q - start_q;
  assign mem_re  = cmd_i.load && sts_o.need_read;

  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    playing_d = playing_q;
    start_d   = start_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    if (cmd_i.load) begin
      res_d = '{status: tss_pkg::StsNone, first_angle: '0, second_angle: '0,
                entry_number: '0};
      case (tss_pkg::action_e'(action_i))
        tss_pkg::ActAdd: begin
          if (count_q < tss_pkg::CountW'(tss_pkg::TableDepth)) begin
            mem_we             = 1'b1;
            res_d.status       = tss_pkg::StsStored;
            res_d.entry_number = tss_pkg::EntryNumW'(count_q);
            count_d            = count_q + tss_pkg::CountW'(1);
          end else begin
            res_d.status = tss_pkg::StsFull;
          end
        end
        tss_pkg::ActBegin: begin
          playing_d = 1'b1;
          pos_d     = '0;
          start_d   = now_time_i;
        end
        tss_pkg::ActEnd: begin
          playing_d = 1'b0;
          start_d   = '0;
        end
        tss_pkg::ActTick: begin
          // every stored entry used: stop and report finished
          if (playing_q && !(pos_q < count_q)) begin
            playing_d    = 1'b0;
            start_d      = '0;
            pos_d        = '0;
            res_d.status = tss_pkg::StsFinished;
          end
        end
        default: begin
          res_d.status = tss_pkg::StsNone;
        end
      endcase
    end else if (cmd_i.eval) begin
      res_d = '{status: tss_pkg::StsNone, first_angle: '0, second_angle: '0,
                entry_number: '0};
      if (elapsed >= tss_pkg::TimeW'(rdata_q[tss_pkg::WordW-1 -: tss_pkg::OffsetW])) begin
        res_d.status       = tss_pkg::StsFired;
        res_d.first_angle  = rdata_q[2*tss_pkg::AngleW-1 -: tss_pkg::AngleW];
        res_d.second_angle = rdata_q[tss_pkg::AngleW-1:0];
        res_d.entry_number = tss_pkg::EntryNumW'(pos_q);
        pos_d              = pos_q + tss_pkg::CountW'(1);
      end
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[count_q[tss_pkg::IdxW-1:0]] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= table_mem[pos_q[tss_pkg::IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      now_q <= now_time_i;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pos_q     <= '0;
      playing_q <= 1'b0;
      start_q   <= '0;
    end else begin
      count_q   <= count_d;
      pos_q     <= pos_d;
      playing_q <= playing_d;
      start_q   <= start_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/timed_setpoint_sequencer_unit.sv
// ----------------------------------------------------------------------------
// timed_setpoint_sequencer_unit
// Stores timed setpoints for two actuators and plays them back on ticks.
// ----------------------------------------------------------------------------
//
//   channel  | role   | carries
//   ---------+--------+-------------------------------------------------------
//   in_i     | sink   | action, now_time, entry_offset, first/second angle
//   out_o    | source | status, out_first/second_angle, entry_number
//
// Results: add, begin, end and a tick that needs no table entry present their
// result in the cycle after the input transaction; a tick with an entry pending
// first does a registered table read, then the 64-bit elapsed-time compare.
// One transaction is in flight at a time: input ready returns the cycle after
// the result transaction completes, so a stalled output holds the input off.
// Reset clears entry count, play position, playing flag and start time; the
// table is not cleared, only entries below the entry count are ever read.
//
module timed_setpoint_sequencer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  tss_in_if.sink        in_i,
  tss_out_if.source     out_o
);

  tss_pkg::cmd_t      cmd;
  tss_pkg::sts_t      sts;
  tss_pkg::out_item_t res;

  // control: hold results until taken, decide whether a table read is needed
  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: table, playback position and timing compare
  tss_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (in_i.action),
    .now_time_i     (in_i.now_time),
    .entry_offset_i (in_i.entry_offset),
    .first_angle_i  (in_i.first_angle),
    .second_angle_i (in_i.second_angle),
    .res_o          (res)
  );

  assign out_o.status           = res.status;
  assign out_o.out_first_angle  = res.first_angle;
  assign out_o.out_second_angle = res.second_angle;
  assign out_o.entry_number     = res.entry_number;

  // never accept while a result is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while result pending");

  // a transaction with no table read gives its result next cycle
  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !sts.need_read) |=> out_o.valid)
    else $error("direct result missing");

  // a table-read tick gives its result after the registered read and the compare
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && sts.need_read) |=> ##1 out_o.valid)
    else $error("tick result missing");

endmodule
